// ===== src/ksd_pkg.sv =====
// Package for the set-1 keyboard scancode decoder.
// Holds prefix and register constants plus the scancode, keycode and character tables.
// No dependencies.
package ksd_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_ENABLED_ADDR = 3'd0;

    localparam logic [7:0] BREAK_BIT_MASK = 8'h80;
    localparam logic [7:0] PREFIX_E0      = 8'hE0;
    localparam logic [7:0] PREFIX_E1      = 8'hE1;
    localparam logic [7:0] SC_LSHIFT      = 8'h2A;
    localparam logic [7:0] SC_RSHIFT      = 8'h36;
    localparam logic [15:0] PAUSE_CODE    = 16'h451D;

    localparam logic [6:0] KC_NONE   = 7'd0;
    localparam logic [6:0] KC_LSHIFT = 7'd42;
    localparam logic [6:0] KC_RSHIFT = 7'd54;
    localparam logic [6:0] KC_PAUSE  = 7'd119;
    localparam logic [6:0] CHAR_ROWS = 7'd84;

    // Plain (non-prefixed) scancode to keycode.
    function automatic logic [6:0] map_plain(input logic [7:0] sc);
        logic [6:0] kc;
        kc = KC_NONE;
        if (sc <= 8'd82)
            kc = sc[6:0];
        else if (sc == 8'd83)
            kc = 7'd84;
        else if (sc >= 8'd86 && sc <= 8'd88)
            kc = sc[6:0];
        return kc;
    endfunction

    // E0-prefixed scancode to keycode.
    function automatic logic [6:0] map_e0(input logic [7:0] sc);
        logic [6:0] kc;
        case (sc)
            8'h1C:   kc = 7'd96;
            8'h1D:   kc = 7'd97;
            8'h35:   kc = 7'd99;
            8'h38:   kc = 7'd100;
            8'h47:   kc = 7'd102;
            8'h48:   kc = 7'd103;
            8'h49:   kc = 7'd104;
            8'h4B:   kc = 7'd105;
            8'h4D:   kc = 7'd106;
            8'h4F:   kc = 7'd107;
            8'h50:   kc = 7'd108;
            8'h51:   kc = 7'd109;
            8'h52:   kc = 7'd110;
            8'h53:   kc = 7'd111;
            default: kc = KC_NONE;
        endcase
        return kc;
    endfunction

    // Keypad rows are the same in both layers.
    function automatic logic [7:0] keypad_char(input logic [6:0] kc);
        logic [7:0] ch;
        case (kc)
            7'd71: ch = 8'h37;  7'd72: ch = 8'h38;  7'd73: ch = 8'h39;
            7'd74: ch = 8'h2D;  7'd75: ch = 8'h34;  7'd76: ch = 8'h35;
            7'd77: ch = 8'h36;  7'd78: ch = 8'h2B;  7'd79: ch = 8'h31;
            7'd80: ch = 8'h32;  7'd81: ch = 8'h33;  7'd82: ch = 8'h30;
            7'd83: ch = 8'h2E;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // German layout, Latin-1, no shift.
    function automatic logic [7:0] plain_char(input logic [6:0] kc);
        logic [7:0] ch;
        case (kc)
            7'd2:  ch = 8'h31;  7'd3:  ch = 8'h32;  7'd4:  ch = 8'h33;
            7'd5:  ch = 8'h34;  7'd6:  ch = 8'h35;  7'd7:  ch = 8'h36;
            7'd8:  ch = 8'h37;  7'd9:  ch = 8'h38;  7'd10: ch = 8'h39;
            7'd11: ch = 8'h30;  7'd12: ch = 8'h2D;  7'd13: ch = 8'h60;
            7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
            7'd16: ch = 8'h71;  7'd17: ch = 8'h77;  7'd18: ch = 8'h65;
            7'd19: ch = 8'h72;  7'd20: ch = 8'h74;  7'd21: ch = 8'h7A;
            7'd22: ch = 8'h75;  7'd23: ch = 8'h69;  7'd24: ch = 8'h6F;
            7'd25: ch = 8'h70;  7'd26: ch = 8'hFC;  7'd27: ch = 8'h2B;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h61;  7'd31: ch = 8'h73;  7'd32: ch = 8'h64;
            7'd33: ch = 8'h66;  7'd34: ch = 8'h67;  7'd35: ch = 8'h68;
            7'd36: ch = 8'h6A;  7'd37: ch = 8'h6B;  7'd38: ch = 8'h6C;
            7'd39: ch = 8'hF6;  7'd40: ch = 8'hE4;  7'd41: ch = 8'h23;
            7'd43: ch = 8'h3C;  7'd44: ch = 8'h79;  7'd45: ch = 8'h78;
            7'd46: ch = 8'h63;  7'd47: ch = 8'h76;  7'd48: ch = 8'h62;
            7'd49: ch = 8'h6E;  7'd50: ch = 8'h6D;  7'd51: ch = 8'h2C;
            7'd52: ch = 8'h2E;  7'd53: ch = 8'h2D;  7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            default: ch = keypad_char(kc);
        endcase
        return ch;
    endfunction

    // German layout, Latin-1, shift held.
    function automatic logic [7:0] shift_char(input logic [6:0] kc);
        logic [7:0] ch;
        case (kc)
            7'd1:  ch = 8'h5E;  7'd2:  ch = 8'h21;  7'd3:  ch = 8'h22;
            7'd5:  ch = 8'h24;  7'd6:  ch = 8'h25;  7'd7:  ch = 8'h26;
            7'd8:  ch = 8'h2F;  7'd9:  ch = 8'h28;  7'd10: ch = 8'h29;
            7'd11: ch = 8'h3D;  7'd12: ch = 8'h3F;  7'd13: ch = 8'h60;
            7'd14: ch = 8'h08;  7'd15: ch = 8'h09;
            7'd16: ch = 8'h51;  7'd17: ch = 8'h57;  7'd18: ch = 8'h45;
            7'd19: ch = 8'h52;  7'd20: ch = 8'h54;  7'd21: ch = 8'h5A;
            7'd22: ch = 8'h55;  7'd23: ch = 8'h49;  7'd24: ch = 8'h4F;
            7'd25: ch = 8'h50;  7'd26: ch = 8'hFC;  7'd27: ch = 8'h2A;
            7'd28: ch = 8'h0A;
            7'd30: ch = 8'h41;  7'd31: ch = 8'h53;  7'd32: ch = 8'h44;
            7'd33: ch = 8'h46;  7'd34: ch = 8'h47;  7'd35: ch = 8'h48;
            7'd36: ch = 8'h4A;  7'd37: ch = 8'h4B;  7'd38: ch = 8'h4C;
            7'd39: ch = 8'hF6;  7'd40: ch = 8'hE4;  7'd41: ch = 8'h27;
            7'd43: ch = 8'h3E;  7'd44: ch = 8'h59;  7'd45: ch = 8'h58;
            7'd46: ch = 8'h43;  7'd47: ch = 8'h56;  7'd48: ch = 8'h42;
            7'd49: ch = 8'h4E;  7'd50: ch = 8'h4D;  7'd51: ch = 8'h3B;
            7'd52: ch = 8'h3A;  7'd53: ch = 8'h5F;  7'd55: ch = 8'h2A;
            7'd57: ch = 8'h20;
            default: ch = keypad_char(kc);
        endcase
        return ch;
    endfunction

endpackage

// ===== src/keyboard_scancode_decoder.sv =====
// Set-1 keyboard scancode decoder, top level.
// Uses ksd_pkg for constants and the keycode / character tables.
//
// Takes one keyboard byte per item and gives at most one result (keycode,
// release flag, German-layout Latin-1 character) per byte. One byte can be
// taken every clock cycle while in_stall is low; each byte passes the input
// register and then the result register, with all decoding and the prefix / shift
// state update done in the single stage between them. Prefix bytes, the first byte
// of the Pause sequence and E0 fake shifts give no result. in_stall only rises
// while a finished result sits in the result register and out_stall is high.
// The enabled register (byte address 0) resets to 0; bytes taken while it is
// 0 are dropped.
module keyboard_scancode_decoder
    import ksd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         scan_byte,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [6:0]         key_code,
    output logic               released,
    output logic [7:0]         char_code
);

    typedef enum logic [1:0] {
        E1_IDLE,
        E1_AWAIT_FIRST,
        E1_AWAIT_SECOND
    } e1_state_t;

    logic        enabled_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        e0_pending_reg, e0_pending_next;
    e1_state_t   e1_stage_reg, e1_stage_next;
    logic [7:0]  e1_first_byte_reg, e1_first_byte_next;
    logic        left_shift_reg, left_shift_next;
    logic        right_shift_reg, right_shift_next;

    logic        out_valid_reg, out_valid_next;
    logic [6:0]  key_code_reg, key_code_next;
    logic        released_reg, released_next;
    logic [7:0]  char_code_reg, char_code_next;

    logic        advance;
    logic        cfg_write;
    logic        brk;
    logic [7:0]  sc;
    logic        emit;
    logic [6:0]  kc;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_write = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ENABLED_ADDR) ? {{(PDATA_W-1){1'b0}}, enabled_reg}
                                                : '0;

    assign out_valid = out_valid_reg;
    assign key_code  = key_code_reg;
    assign released  = released_reg;
    assign char_code = char_code_reg;

    always_comb
    begin
        e0_pending_next    = e0_pending_reg;
        e1_stage_next      = e1_stage_reg;
        e1_first_byte_next = e1_first_byte_reg;
        left_shift_next    = left_shift_reg;
        right_shift_next   = right_shift_reg;
        emit               = 1'b0;
        kc                 = KC_NONE;

        // E0/E1 keep their top bit when they act as a prefix
        brk = ((in_byte_reg & BREAK_BIT_MASK) != 8'h00)
              && (e1_stage_reg != E1_IDLE || in_byte_reg != PREFIX_E1)
              && (e0_pending_reg || in_byte_reg != PREFIX_E0);
        sc  = brk ? (in_byte_reg & ~BREAK_BIT_MASK) : in_byte_reg;

        if (in_valid_reg && advance && enabled_reg)
        begin
            if (e0_pending_reg)
            begin
                e0_pending_next = 1'b0;
                if (sc != SC_LSHIFT && sc != SC_RSHIFT)
                begin
                    emit = 1'b1;
                    kc   = map_e0(sc);
                end
            end
            else
            begin
                case (e1_stage_reg)
                    E1_IDLE:
                    begin
                        if (sc == PREFIX_E0)
                            e0_pending_next = 1'b1;
                        else if (sc == PREFIX_E1)
                            e1_stage_next = E1_AWAIT_FIRST;
                        else
                        begin
                            emit = 1'b1;
                            kc   = map_plain(sc);
                        end
                    end
                    E1_AWAIT_SECOND:
                    begin
                        emit          = 1'b1;
                        kc            = ({sc, e1_first_byte_reg} == PAUSE_CODE) ? KC_PAUSE
                                                                                : KC_NONE;
                        e1_stage_next = E1_IDLE;
                    end
                    default:
                    begin
                        e1_first_byte_next = sc;
                        e1_stage_next      = E1_AWAIT_SECOND;
                    end
                endcase
            end
        end

        if (emit && kc == KC_LSHIFT)
            left_shift_next = !brk;
        if (emit && kc == KC_RSHIFT)
            right_shift_next = !brk;

        char_code_next = 8'h00;
        if (!brk && kc < CHAR_ROWS)
            char_code_next = (left_shift_next || right_shift_next) ? shift_char(kc)
                                                                   : plain_char(kc);

        out_valid_next = advance ? emit : out_valid_reg;
        key_code_next  = kc;
        released_next  = brk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg       <= 1'b0;
            in_valid_reg      <= 1'b0;
            e0_pending_reg    <= 1'b0;
            e1_stage_reg      <= E1_IDLE;
            e1_first_byte_reg <= 8'h00;
            left_shift_reg    <= 1'b0;
            right_shift_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write && paddr == REG_ENABLED_ADDR)
                enabled_reg <= pwdata[0];

            if (!in_stall)
                in_valid_reg <= in_valid;

            e0_pending_reg    <= e0_pending_next;
            e1_stage_reg      <= e1_stage_next;
            e1_first_byte_reg <= e1_first_byte_next;
            left_shift_reg    <= left_shift_next;
            right_shift_reg   <= right_shift_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= scan_byte;
        if (advance && emit)
        begin
            key_code_reg  <= key_code_next;
            released_reg  <= released_next;
            char_code_reg <= char_code_next;
        end
    end

    a_release_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && released |-> char_code == 8'h00)
        else $error("release item carries a character");

    a_prefix_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(e0_pending_reg && e1_stage_reg != E1_IDLE))
        else $error("E0 and E1 prefixes pending together");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_unknown_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_code == KC_NONE |-> char_code == 8'h00)
        else $error("unknown keycode carries a character");

endmodule

// ===== dv/keyboard_scancode_decoder_tb.sv =====
// Self-checking testbench for keyboard_scancode_decoder: directed rows, then random
// keystroke sequences, checked against an in-bench scancode/keycode/character predictor.
// Depends on ksd_pkg and the keyboard_scancode_decoder RTL.
module keyboard_scancode_decoder_tb
    import ksd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PIPE_SLACK = 6;

    typedef struct packed {
        logic [6:0] key_code;
        logic       released;
        logic [7:0] char_code;
    } key_event_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_SILENT} row_kind_t;

    typedef struct packed {
        logic [7:0] scan;
        row_kind_t  kind;
        key_event_t ev;
    } directed_row_t;

    typedef enum logic [1:0] {E1_IDLE, E1_FIRST, E1_SECOND} pause_step_t;

    // Keycode -> Latin-1, German layout
    localparam logic [7:0] PLAIN_LAYER [84] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h60, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h7A, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'hFC, 8'h2B, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hF6,
        8'hE4, 8'h23, 8'h00, 8'h3C, 8'h79, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] SHIFT_LAYER [84] = '{
        8'h00, 8'h5E, 8'h21, 8'h22, 8'h00, 8'h24, 8'h25, 8'h26,
        8'h2F, 8'h28, 8'h29, 8'h3D, 8'h3F, 8'h60, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h5A, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'hFC, 8'h2A, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hF6,
        8'hE4, 8'h27, 8'h00, 8'h3E, 8'h59, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    // Extended (E0) scancodes and the keycodes they give
    localparam logic [7:0] E0_SCANS [14] = '{
        8'h1C, 8'h1D, 8'h35, 8'h38, 8'h47, 8'h48, 8'h49,
        8'h4B, 8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53
    };
    localparam logic [6:0] E0_KEYS [14] = '{
        7'd96,  7'd97,  7'd99,  7'd100, 7'd102, 7'd103, 7'd104,
        7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111
    };

    localparam directed_row_t DIRECTED_ROWS [26] = '{
        '{8'h00, ROW_FIXED,   '{KC_NONE, 1'b0, 8'h00}},
        '{8'h1E, ROW_PREDICT, '0},
        '{SC_LSHIFT, ROW_FIXED, '{KC_LSHIFT, 1'b0, 8'h00}},
        '{8'h1E, ROW_PREDICT, '0},
        '{8'hAA, ROW_FIXED,   '{KC_LSHIFT, 1'b1, 8'h00}},
        '{8'hFF, ROW_FIXED,   '{KC_NONE, 1'b1, 8'h00}},
        '{8'h53, ROW_FIXED,   '{7'd84, 1'b0, 8'h00}},
        '{SC_RSHIFT, ROW_FIXED, '{KC_RSHIFT, 1'b0, 8'h00}},
        '{8'h02, ROW_PREDICT, '0},
        '{8'hB6, ROW_FIXED,   '{KC_RSHIFT, 1'b1, 8'h00}},
        '{PREFIX_E0, ROW_SILENT, '0},
        '{8'h1C, ROW_FIXED,   '{7'd96, 1'b0, 8'h00}},
        // fake shift break behind E0
        '{PREFIX_E0, ROW_SILENT, '0},
        '{8'hAA, ROW_SILENT,  '0},
        // E1 right after E0: looked up as extended, no entry
        '{PREFIX_E0, ROW_SILENT, '0},
        '{PREFIX_E1, ROW_FIXED, '{KC_NONE, 1'b0, 8'h00}},
        // pause make and break
        '{PREFIX_E1, ROW_SILENT, '0},
        '{8'h1D, ROW_SILENT,  '0},
        '{8'h45, ROW_FIXED,   '{KC_PAUSE, 1'b0, 8'h00}},
        '{PREFIX_E1, ROW_SILENT, '0},
        '{8'h9D, ROW_SILENT,  '0},
        '{8'hC5, ROW_FIXED,   '{KC_PAUSE, 1'b1, 8'h00}},
        // E0 inside E1 is plain data
        '{PREFIX_E1, ROW_SILENT, '0},
        '{PREFIX_E0, ROW_SILENT, '0},
        '{PREFIX_E0, ROW_FIXED, '{KC_NONE, 1'b0, 8'h00}},
        '{PREFIX_E0, ROW_SILENT, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         scan_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [6:0]         key_code;
    logic               released;
    logic [7:0]         char_code;

    // predictor state
    logic        kbd_enabled = 1'b0;
    logic        e0_seen = 1'b0;
    pause_step_t e1_step = E1_IDLE;
    logic [7:0]  e1_low_byte = 8'h00;
    logic        lshift_held = 1'b0;
    logic        rshift_held = 1'b0;

    key_event_t  pending_keys [$];
    int unsigned error_count = 0;
    int unsigned sent_bytes = 0;
    int unsigned burst_left = 0;

    // receiver stall pattern
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_phase = 0;

    keyboard_scancode_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .scan_byte (scan_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_code  (key_code),
        .released  (released),
        .char_code (char_code)
    );

    always #2 clk = ~clk;

    // Decode one byte, update prefix and shift state; returns 1 when a key event results.
    function automatic bit decode_scan(input logic [7:0] raw, output key_event_t ev);
        logic [7:0]  sc;
        logic        brk;
        logic [6:0]  kc;
        logic [15:0] pause_word;
        ev = '0;
        if (!kbd_enabled)
            return 1'b0;
        brk = raw[7] && (e1_step != E1_IDLE || raw != PREFIX_E1)
                     && (e0_seen || raw != PREFIX_E0);
        sc = brk ? (raw & ~BREAK_BIT_MASK) : raw;
        kc = KC_NONE;
        if (e0_seen)
        begin
            e0_seen = 1'b0;
            if (sc == SC_LSHIFT || sc == SC_RSHIFT)
                return 1'b0;
            for (int i = 0; i < 14; i++)
                if (E0_SCANS[i] == sc)
                    kc = E0_KEYS[i];
        end
        else if (e1_step == E1_SECOND)
        begin
            pause_word = {sc, e1_low_byte};
            kc = (pause_word == PAUSE_CODE) ? KC_PAUSE : KC_NONE;
            e1_step = E1_IDLE;
        end
        else if (e1_step != E1_IDLE)
        begin
            e1_low_byte = sc;
            e1_step = E1_SECOND;
            return 1'b0;
        end
        else if (sc == PREFIX_E0)
        begin
            e0_seen = 1'b1;
            return 1'b0;
        end
        else if (sc == PREFIX_E1)
        begin
            e1_step = E1_FIRST;
            return 1'b0;
        end
        else if (sc <= 8'd82 || (sc >= 8'd86 && sc <= 8'd88))
            kc = sc[6:0];
        else if (sc == 8'd83)
            kc = 7'd84;

        if (kc == KC_LSHIFT)
            lshift_held = !brk;
        if (kc == KC_RSHIFT)
            rshift_held = !brk;

        ev.key_code = kc;
        ev.released = brk;
        if (!brk && kc < CHAR_ROWS)
            ev.char_code = (lshift_held || rshift_held) ? SHIFT_LAYER[kc] : PLAIN_LAYER[kc];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_byte(input logic [7:0] raw, input row_kind_t kind,
                             input key_event_t typed);
        int unsigned gap;
        key_event_t  ev;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        scan_byte <= raw;
        do
            @(posedge clk);
        while (in_stall);
        sent_bytes++;
        if (decode_scan(raw, ev) && kind == ROW_PREDICT)
            pending_keys.push_back(ev);
        if (kind == ROW_FIXED)
            pending_keys.push_back(typed);
    endtask

    task automatic send_scan(input logic [7:0] raw);
        send_byte(raw, ROW_PREDICT, '0);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_keys.size() != 0)
            @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_ENABLED_ADDR)
            kbd_enabled = value[0];
    endtask

    // Mostly well-formed keystrokes with random content, some broken prefixes and noise.
    task automatic send_keystrokes();
        int unsigned pick;
        int unsigned idx;
        logic [7:0]  code;
        logic [7:0]  brk_bit;
        pick = $urandom_range(0, 99);
        brk_bit = $urandom_range(0, 1) ? BREAK_BIT_MASK : 8'h00;
        if (pick < 35)
        begin
            code = 8'($urandom_range(1, 8'h58));
            send_scan(code);
            if ($urandom_range(0, 1))
                send_scan(code | BREAK_BIT_MASK);
        end
        else if (pick < 50)
            send_scan(($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT) | brk_bit);
        else if (pick < 65)
        begin
            idx = $urandom_range(0, 13);
            send_scan(PREFIX_E0);
            send_scan(E0_SCANS[idx] | brk_bit);
        end
        else if (pick < 72)
        begin
            send_scan(PREFIX_E0);
            send_scan(($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT) | brk_bit);
        end
        else if (pick < 80)
        begin
            send_scan(PREFIX_E1);
            send_scan(PAUSE_CODE[7:0] | brk_bit);
            send_scan(PAUSE_CODE[15:8] | brk_bit);
        end
        else if (pick < 86)
        begin
            send_scan($urandom_range(0, 1) ? PREFIX_E0 : PREFIX_E1);
            send_scan(8'($urandom_range(0, 255)));
        end
        else
            send_scan(8'($urandom_range(0, 255)));
    endtask

    task automatic run_keystrokes(input int unsigned count);
        int unsigned start;
        start = sent_bytes;
        while (sent_bytes - start < count)
            send_keystrokes();
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin : result_check
        key_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_keys.size() == 0)
                report_mismatch("unexpected item, key_code", 0, 32'(key_code));
            else
            begin
                want = pending_keys.pop_front();
                if (key_code !== want.key_code)
                    report_mismatch("key_code", 32'(want.key_code), 32'(key_code));
                if (released !== want.released)
                    report_mismatch("released", 32'(want.released), 32'(released));
                if (char_code !== want.char_code)
                    report_mismatch("char_code", 32'(want.char_code), 32'(char_code));
            end
        end

        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 11;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= (stall_phase < 6);
        endcase
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // disabled after reset: everything dropped
        send_scan(PREFIX_E0);
        repeat (20) send_scan(8'($urandom_range(0, 255)));
        wait_for_idle();

        apb_write(REG_ENABLED_ADDR, 32'h0000_0001);
        foreach (DIRECTED_ROWS[i])
            send_byte(DIRECTED_ROWS[i].scan, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].ev);
        wait_for_idle();

        run_keystrokes(130);
        wait_for_idle();
        run_keystrokes(130);
        wait_for_idle();

        // upper data bits are don't-care; bit 0 clears enable
        apb_write(REG_ENABLED_ADDR, 32'hFFFF_FFFE);
        repeat (30) send_scan(8'($urandom_range(0, 255)));
        wait_for_idle();

        apb_write(REG_ENABLED_ADDR, 32'hFFFF_FFFF);
        run_keystrokes(160);
        wait_for_idle();

        apb_write(REG_ENABLED_ADDR, 32'h0000_0000);
        repeat (10) send_scan(8'($urandom_range(0, 255)));
        wait_for_idle();

        repeat (2 * PIPE_SLACK) @(posedge clk);
        if (error_count == 0)
            $display("keyboard_scancode_decoder regression: pass");
        else
            $display("keyboard_scancode_decoder regression: fail");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("keyboard_scancode_decoder regression: fail");
        $finish;
    end

endmodule
